### src/vp8d_pkg.sv
// Package: beat types and descriptor constants for the VP8 RTP payload deframer.
`timescale 1ns / 1ps
`default_nettype none
package vp8d_pkg;

    localparam logic [7:0] SYNC_MASK  = 8'h1F;
    localparam logic [7:0] SYNC_VALUE = 8'h10;
    localparam logic [7:0] BIT_X      = 8'h80;
    localparam logic [7:0] BIT_I      = 8'h80;
    localparam logic [7:0] BIT_L      = 8'h40;
    localparam logic [7:0] BIT_TK     = 8'h30;
    localparam logic [7:0] BIT_M      = 8'h80;
    localparam logic [7:0] BIT_INTER  = 8'h01;

    localparam logic [1:0] POS_LAST   = 2'd3;
    localparam logic [2:0] DESC_RESET = 3'd1;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_ABORT = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       packet_first;
        logic       packet_last;
        logic       marker_bit;
        logic       discontinuity;
    } in_beat_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   frame_byte;
        logic         frame_end;
        logic         is_keyframe;
    } out_beat_t;

    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } step_result_t;

endpackage
`default_nettype wire

### src/vp8d_parser.sv
// Descriptor parser and frame tracker: state registers and per-beat next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module vp8d_parser
    import vp8d_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire in_beat_t     beat,
    output step_result_t      outcome
);

    logic       frame_started_reg, frame_started_next;
    logic       frame_has_bytes_reg, frame_has_bytes_next;
    logic [1:0] byte_position_reg, byte_position_next;
    logic [2:0] descriptor_length_reg, descriptor_length_next;
    logic       picture_id_present_reg, picture_id_present_next;
    logic       packet_skipped_reg, packet_skipped_next;
    logic       packet_payload_seen_reg, packet_payload_seen_next;
    logic       delta_frame_reg, delta_frame_next;

    always_comb
    begin
        logic [1:0] pos;
        logic [2:0] dl;
        logic       abort_out;
        logic       data_out;
        logic       end_out;
        logic [7:0] b;

        b         = beat.payload_byte;
        abort_out = 1'b0;
        data_out  = 1'b0;
        end_out   = 1'b0;

        pos                      = byte_position_reg;
        dl                       = descriptor_length_reg;
        picture_id_present_next  = picture_id_present_reg;
        packet_skipped_next      = packet_skipped_reg;
        packet_payload_seen_next = packet_payload_seen_reg;
        frame_started_next       = frame_started_reg;
        frame_has_bytes_next     = frame_has_bytes_reg;
        delta_frame_next         = delta_frame_reg;

        if (beat.packet_first)
        begin
            pos                      = 2'd0;
            dl                       = DESC_RESET;
            picture_id_present_next  = 1'b0;
            packet_skipped_next      = 1'b0;
            packet_payload_seen_next = 1'b0;
            if (beat.discontinuity)
            begin
                abort_out            = frame_has_bytes_next;
                frame_started_next   = 1'b0;
                frame_has_bytes_next = 1'b0;
            end
        end

        if (!packet_skipped_next && pos == 2'd0 && !frame_started_next)
        begin
            if ((b & SYNC_MASK) != SYNC_VALUE)
                packet_skipped_next = 1'b1;
            else
                frame_started_next = 1'b1;
        end

        if (!packet_skipped_next)
        begin
            if (dl != 3'd0)
            begin
                dl = dl - 3'd1;
                case (pos)
                    2'd0:
                    begin
                        if ((b & BIT_X) != 8'h00)
                            dl = dl + 3'd1;
                    end
                    2'd1:
                    begin
                        if ((b & BIT_I) != 8'h00)
                        begin
                            dl = dl + 3'd1;
                            picture_id_present_next = 1'b1;
                        end
                        if ((b & BIT_L) != 8'h00)
                            dl = dl + 3'd1;
                        if ((b & BIT_TK) != 8'h00)
                            dl = dl + 3'd1;
                    end
                    2'd2:
                    begin
                        if (picture_id_present_next && (b & BIT_M) != 8'h00)
                            dl = dl + 3'd1;
                    end
                    default:
                    begin
                        dl = dl;
                    end
                endcase
            end
            else
            begin
                data_out                 = 1'b1;
                packet_payload_seen_next = 1'b1;
                if (!frame_has_bytes_next)
                    delta_frame_next = ((b & BIT_INTER) != 8'h00);
                frame_has_bytes_next = 1'b1;
                if (beat.packet_last && beat.marker_bit)
                begin
                    end_out              = 1'b1;
                    frame_started_next   = 1'b0;
                    frame_has_bytes_next = 1'b0;
                end
            end
            if (beat.packet_last && !packet_payload_seen_next)
            begin
                abort_out            = abort_out | frame_has_bytes_next;
                frame_started_next   = 1'b0;
                frame_has_bytes_next = 1'b0;
            end
        end

        if (beat.packet_last)
            packet_skipped_next = 1'b1;

        byte_position_next     = (pos == POS_LAST) ? POS_LAST : pos + 2'd1;
        descriptor_length_next = dl;

        outcome.valid = abort_out | data_out;
        if (abort_out)
        begin
            outcome.beat.result_kind = KIND_ABORT;
            outcome.beat.frame_byte  = 8'h00;
            outcome.beat.frame_end   = 1'b0;
            outcome.beat.is_keyframe = 1'b0;
        end
        else
        begin
            outcome.beat.result_kind = KIND_DATA;
            outcome.beat.frame_byte  = data_out ? b : 8'h00;
            outcome.beat.frame_end   = end_out;
            outcome.beat.is_keyframe = end_out & ~delta_frame_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_started_reg       <= 1'b0;
            frame_has_bytes_reg     <= 1'b0;
            byte_position_reg       <= 2'd0;
            descriptor_length_reg   <= DESC_RESET;
            picture_id_present_reg  <= 1'b0;
            packet_skipped_reg      <= 1'b0;
            packet_payload_seen_reg <= 1'b0;
            delta_frame_reg         <= 1'b0;
        end
        else if (step)
        begin
            frame_started_reg       <= frame_started_next;
            frame_has_bytes_reg     <= frame_has_bytes_next;
            byte_position_reg       <= byte_position_next;
            descriptor_length_reg   <= descriptor_length_next;
            picture_id_present_reg  <= picture_id_present_next;
            packet_skipped_reg      <= packet_skipped_next;
            packet_payload_seen_reg <= packet_payload_seen_next;
            delta_frame_reg         <= delta_frame_next;
        end
    end

endmodule
`default_nettype wire

### src/vp8_rtp_payload_deframer.sv
// Top level of the VP8 RTP payload deframer: input register, parser, result register.
//
//   channel   direction  handshake                      beat
//   item      in         item_valid / item_stall        in_beat_t
//   result    out        result_valid / result_stall    out_beat_t
//
// One beat per cycle sustained while result_stall is low; an accepted beat goes
// through the input register, then the result register.
// Beats that yield nothing (descriptor bytes, skipped packets) leave no result.
// Reset clears both registers' valid flags and the parser state.
// result_stall holds the result register and, once the input register is full, item_stall.
`timescale 1ns / 1ps
`default_nettype none
module vp8_rtp_payload_deframer
    import vp8d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_beat_t  item,
    input  wire logic      item_valid,
    output logic           item_stall,
    output out_beat_t      result,
    output logic           result_valid,
    input  wire logic      result_stall
);

    logic         hold_valid_reg, hold_valid_next;
    in_beat_t     hold_reg;
    logic         res_valid_reg, res_valid_next;
    out_beat_t    res_reg;
    logic         advance;
    logic         accept;
    step_result_t outcome;

    assign advance    = hold_valid_reg & (~res_valid_reg | ~result_stall);
    assign item_stall = hold_valid_reg & ~advance;
    assign accept     = item_valid & ~item_stall;

    vp8d_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .beat    (hold_reg),
        .outcome (outcome)
    );

    always_comb
    begin
        if (accept)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;

        if (advance)
            res_valid_next = outcome.valid;
        else if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= item;
        if (advance && outcome.valid)
            res_reg <= outcome.beat;
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule
`default_nettype wire

### src/vp8d_checker.sv
// Port checker for the VP8 RTP payload deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vp8d_checker
    import vp8d_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire in_beat_t  item,
    input wire logic      item_valid,
    input wire logic      item_stall,
    input wire out_beat_t result,
    input wire logic      result_valid,
    input wire logic      result_stall
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_kind == KIND_ABORT |->
            result.frame_byte == 8'h00 && !result.frame_end && !result.is_keyframe)
        else $error("abort beat carries frame fields");

    a_key_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_keyframe |->
            result.frame_end && result.result_kind == KIND_DATA)
        else $error("keyframe flag without frame end");

    a_no_stall_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled while result side empty");

    a_item_known: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> !$isunknown(item))
        else $error("input beat has unknown bits");

endmodule

bind vp8_rtp_payload_deframer vp8d_checker u_vp8d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
`default_nettype wire
